>>> hw/rtl/psh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types and constants for the polynomial string hash block.
// ----------------------------------------------------------------------------
package psh_pkg;

   localparam int unsigned DataWidth     = 32;
   localparam int unsigned CharWidth     = 8;
   localparam int unsigned CsrIndexWidth = 8;
   localparam int unsigned CountWidth    = $clog2(DataWidth);

   localparam logic [DataWidth-1:0] CharOffset     = 32'd96;
   localparam logic [DataWidth-1:0] HashBaseReset  = 32'd31;
   localparam logic [DataWidth-1:0] TableSizeReset = 32'd11;

   localparam logic [CsrIndexWidth-1:0] CSR_HASH_BASE  = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TABLE_SIZE = 8'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/polynomial_string_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_string_hash
// Horner hash over a word streamed one character per word on req, reduced
// modulo the table size by a bit-serial restoring divider on the last char.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid/req_ready   | req_char_code, req_last_char
//   rsp     | out | rsp_valid/rsp_ready   | rsp_hash_index
//   csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// A non-final character is accepted and then multiply-accumulated. A final
// character is accepted, multiply-accumulated, put through 32 steps of the
// shared subtract-compare unit and loaded as the result. Zero table size
// skips the 32 steps. req_ready is low while a character is in flight; the
// result load waits while an earlier result is still held on rsp. Reset is
// synchronous and restores the register defaults and a clear accumulator.
// ----------------------------------------------------------------------------
module polynomial_string_hash (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [psh_pkg::CharWidth-1:0] req_char_code,
   input  logic                                req_last_char,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [psh_pkg::DataWidth-1:0]       rsp_hash_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psh_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [psh_pkg::DataWidth-1:0]       csr_data
);
   import psh_pkg::*;

   state_type              state_ff, state_in;
   logic [DataWidth-1:0]   acc_ff, acc_in;
   logic [DataWidth-1:0]   base_ff, size_ff;
   logic [CharWidth-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;
   logic [DataWidth-1:0]   rem_ff, rem_in;
   logic [DataWidth-1:0]   dvd_ff, dvd_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]   rsp_hash_ff, rsp_hash_in;

   logic [DataWidth-1:0]   product;
   logic [DataWidth-1:0]   term;
   logic [DataWidth-1:0]   mac_sum;
   logic [DataWidth:0]     rem_shift;
   logic [DataWidth:0]     rem_diff;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_index = rsp_hash_ff;
   assign csr_ready      = 1'b1;

   // shared multiply-accumulate and subtract-compare
   always_comb begin
      product   = acc_ff * base_ff;
      term      = {{(DataWidth-CharWidth){char_ff[CharWidth-1]}}, char_ff} - CharOffset;
      mac_sum   = product + term;
      rem_shift = {rem_ff, dvd_ff[DataWidth-1]};
      rem_diff  = rem_shift - {1'b0, size_ff};
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               char_in  = req_char_code;
               last_in  = req_last_char;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (!last_ff) begin
               acc_in   = mac_sum;
               state_in = ST_IDLE;
            end else begin
               acc_in   = '0;
               count_in = '0;
               if (size_ff == '0) begin
                  rem_in   = mac_sum;
                  state_in = ST_DONE;
               end else begin
                  rem_in   = '0;
                  dvd_in   = mac_sum;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // rem_shift is below twice size, so the remainder fits 32 bits
            rem_in   = rem_diff[DataWidth] ? rem_shift[DataWidth-1:0]
                                           : rem_diff[DataWidth-1:0];
            dvd_in   = {dvd_ff[DataWidth-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == CountWidth'(DataWidth-1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = rem_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      last_ff     <= last_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= HashBaseReset;
         size_ff <= TableSizeReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HASH_BASE:  base_ff <= csr_data;
            CSR_TABLE_SIZE: size_ff <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

>>> hw/rtl/psh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_checker
// Port-level checks on the polynomial string hash, bound to the top level.
// ----------------------------------------------------------------------------
module psh_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_last_char,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [psh_pkg::DataWidth-1:0]     rsp_hash_index
);
   import psh_pkg::*;

   // a held result word keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_index))
      else $error("rsp word dropped or changed while stalled");

   // nothing is shown straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // any accepted char blocks req for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high during multiply-accumulate");

   // a non-final char frees req once its multiply-accumulate is done
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_char |=> ##1 req_ready)
      else $error("req_ready late after a non-final char");

   // a final char accepted with no result held shows none in the MAC state or the state after it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_char && !rsp_valid |=> !rsp_valid [*2])
      else $error("rsp word appeared too early");

endmodule

bind polynomial_string_hash psh_checker u_psh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last_char  (req_last_char),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_index (rsp_hash_index)
);
